FILE: hdl/hsv_pkg.sv
// ----------------------------------------------------------------------------
// hsv_pkg
// Shared types and constants for the HSV to RGB converter pipeline.
// ----------------------------------------------------------------------------
package hsv_pkg;

  typedef logic [15:0] q15_t;
  typedef logic [2:0]  sector_t;

  localparam q15_t         ONE       = 16'h8000;
  localparam logic [12:0]  SPAN      = 13'd960;
  localparam logic [12:0]  HUE_LIMIT = 13'd5760;
  localparam logic [9:0]   SPAN_F    = 10'd960;
  // floor(q/15) estimate: (q * RECIP15) >> 16, at most one low
  localparam logic [12:0]  RECIP15   = 13'd4369;
  localparam logic [4:0]   DIV_REST  = 5'd15;

  localparam sector_t SEC_R_TO_Y = 3'd0;
  localparam sector_t SEC_Y_TO_G = 3'd1;
  localparam sector_t SEC_G_TO_C = 3'd2;
  localparam sector_t SEC_C_TO_B = 3'd3;
  localparam sector_t SEC_B_TO_M = 3'd4;
  localparam sector_t SEC_M_TO_R = 3'd5;

  typedef struct packed {
    logic    grey;
    sector_t sector;
    logic [9:0] fsel;
    q15_t    sat;
    q15_t    val;
  } hsv_s1_t;

  typedef struct packed {
    logic    grey;
    sector_t sector;
    logic [9:0] fsel;
    q15_t    chroma;
    q15_t    val;
  } hsv_s2_t;

  typedef struct packed {
    logic    grey;
    sector_t sector;
    q15_t    chroma;
    q15_t    m;
    logic [18:0] quo;
  } hsv_s3_t;

  typedef struct packed {
    logic    grey;
    sector_t sector;
    q15_t    chroma;
    q15_t    m;
    logic [18:0] quo;
    logic [14:0] est;
  } hsv_s4_t;

endpackage

FILE: hdl/hsv_in_if.sv
// ----------------------------------------------------------------------------
// hsv_in_if
// Input channel: one HSV color per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hsv_in_if;
  logic        valid;
  logic        ready;
  logic [12:0] hue;
  logic [15:0] saturation;
  logic [15:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink (input valid, input hue, input saturation, input brightness,
                output ready);
endinterface

FILE: hdl/hsv_out_if.sv
// ----------------------------------------------------------------------------
// hsv_out_if
// Output channel: one RGB color per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hsv_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] red;
  logic [15:0] green;
  logic [15:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

FILE: hdl/hsv_to_rgb_converter_unit.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit
// HSV to RGB color conversion in Q1.15, five register stages.
// ----------------------------------------------------------------------------
// Usage:
//   pix_in carries one color per item: hue in 1/16 degree (0..5759),
//   saturation and brightness in Q1.15 (values above 1.0 are clamped).
//   pix_out returns red, green, blue in Q1.15, one item per input item,
//   in order. Hue of 5760 and above yields grey (all channels = v - chroma).
//   An accepted item enters the first of the five register stages at the
//   accepting edge; pix_out.valid rises when it reaches the fifth.
//   Throughput: one item per cycle when not stalled; set by the five-stage
//   pipeline with two multipliers (v*s, chroma*f) and a reciprocal multiply
//   for the /960. Each stage holds its item while the next is full, so
//   bubbles close up and pix_in.ready stays high while any stage is free; a
//   stall on pix_out backs up stage by stage, nothing dropped or repeated.
//   Reset (rst, synchronous) empties all stages; pix_out.valid goes low.
//   No configuration and no state between items.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_unit
  import hsv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  hsv_in_if.sink     pix_in,
  hsv_out_if.source  pix_out
);

  logic    front_valid;
  logic    front_ready;
  hsv_s2_t front_data;
  logic    scale_valid;
  logic    scale_ready;
  hsv_s4_t scale_data;

  hsv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (pix_in.valid),
    .up_ready   (pix_in.ready),
    .hue        (pix_in.hue),
    .saturation (pix_in.saturation),
    .brightness (pix_in.brightness),
    .dn_valid   (front_valid),
    .dn_ready   (front_ready),
    .dn_data    (front_data)
  );

  hsv_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .up_valid (front_valid),
    .up_ready (front_ready),
    .up_data  (front_data),
    .dn_valid (scale_valid),
    .dn_ready (scale_ready),
    .dn_data  (scale_data)
  );

  hsv_mix u_mix (
    .clk      (clk),
    .rst      (rst),
    .up_valid (scale_valid),
    .up_ready (scale_ready),
    .up_data  (scale_data),
    .dn_valid (pix_out.valid),
    .dn_ready (pix_out.ready),
    .red      (pix_out.red),
    .green    (pix_out.green),
    .blue     (pix_out.blue)
  );

`ifndef SYNTH
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    (!pix_out.valid || pix_out.ready) |-> pix_in.ready)
    else $error("input stalled while output side is free");

  a_range: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid |-> (pix_out.red <= ONE && pix_out.green <= ONE && pix_out.blue <= ONE))
    else $error("channel above 1.0");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (pix_out.valid && !pix_out.ready) |=> (pix_out.valid && $stable(pix_out.red) &&
      $stable(pix_out.green) && $stable(pix_out.blue)))
    else $error("output item changed while stalled");
`endif

endmodule

FILE: hdl/hsv_front.sv
// ----------------------------------------------------------------------------
// hsv_front
// Stages 1-2: clamp inputs, split hue into sector and fraction, form chroma.
// ----------------------------------------------------------------------------
module hsv_front
  import hsv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        up_valid,
  output logic        up_ready,
  input  logic [12:0] hue,
  input  q15_t        saturation,
  input  q15_t        brightness,
  output logic        dn_valid,
  input  logic        dn_ready,
  output hsv_s2_t     dn_data
);

  logic    v1;
  hsv_s1_t s1;
  hsv_s1_t s1_next;
  logic    ready1;
  logic    ready2;
  logic [12:0] base;
  logic [12:0] frac;
  logic [31:0] prod;

  assign ready2   = !dn_valid || dn_ready;
  assign ready1   = !v1 || ready2;
  assign up_ready = ready1;

  always_comb begin
    s1_next.sat  = (saturation > ONE) ? ONE : saturation;
    s1_next.val  = (brightness > ONE) ? ONE : brightness;
    s1_next.grey = (hue >= HUE_LIMIT);
    priority if (hue >= 13'(5 * SPAN)) begin
      s1_next.sector = SEC_M_TO_R;
      base = 13'(5 * SPAN);
    end else if (hue >= 13'(4 * SPAN)) begin
      s1_next.sector = SEC_B_TO_M;
      base = 13'(4 * SPAN);
    end else if (hue >= 13'(3 * SPAN)) begin
      s1_next.sector = SEC_C_TO_B;
      base = 13'(3 * SPAN);
    end else if (hue >= 13'(2 * SPAN)) begin
      s1_next.sector = SEC_G_TO_C;
      base = 13'(2 * SPAN);
    end else if (hue >= SPAN) begin
      s1_next.sector = SEC_Y_TO_G;
      base = SPAN;
    end else begin
      s1_next.sector = SEC_R_TO_Y;
      base = 13'd0;
    end
    frac = hue - base;
    s1_next.fsel = s1_next.sector[0] ? (SPAN_F - frac[9:0]) : frac[9:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= up_valid;
    end
    if (ready1 && up_valid) begin
      s1 <= s1_next;
    end
  end

  assign prod = 32'(s1.val) * 32'(s1.sat);

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (ready2) begin
      dn_valid <= v1;
    end
    if (ready2 && v1) begin
      dn_data.grey   <= s1.grey;
      dn_data.sector <= s1.sector;
      dn_data.fsel   <= s1.fsel;
      dn_data.chroma <= prod[30:15];
      dn_data.val    <= s1.val;
    end
  end

endmodule

FILE: hdl/hsv_scale.sv
// ----------------------------------------------------------------------------
// hsv_scale
// Stages 3-4: chroma times hue fraction and m = v - chroma, then reciprocal estimate of /960.
// ----------------------------------------------------------------------------
module hsv_scale
  import hsv_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    up_valid,
  output logic    up_ready,
  input  hsv_s2_t up_data,
  output logic    dn_valid,
  input  logic    dn_ready,
  output hsv_s4_t dn_data
);

  logic        v3;
  hsv_s3_t     s3;
  logic        ready3;
  logic        ready4;
  logic [25:0] xprod;
  logic [31:0] rprod;

  assign ready4   = !dn_valid || dn_ready;
  assign ready3   = !v3 || ready4;
  assign up_ready = ready3;

  assign xprod = 26'(up_data.chroma) * 26'(up_data.fsel);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ready3) begin
      v3 <= up_valid;
    end
    if (ready3 && up_valid) begin
      s3.grey   <= up_data.grey;
      s3.sector <= up_data.sector;
      s3.chroma <= up_data.chroma;
      s3.m      <= up_data.val - up_data.chroma;
      s3.quo    <= xprod[24:6];
    end
  end

  // 960 = 64 * 15: shift first, then divide by 15
  assign rprod = 32'(s3.quo) * 32'(RECIP15);

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (ready4) begin
      dn_valid <= v3;
    end
    if (ready4 && v3) begin
      dn_data.grey   <= s3.grey;
      dn_data.sector <= s3.sector;
      dn_data.chroma <= s3.chroma;
      dn_data.m      <= s3.m;
      dn_data.quo    <= s3.quo;
      dn_data.est    <= rprod[30:16];
    end
  end

endmodule

FILE: hdl/hsv_mix.sv
// ----------------------------------------------------------------------------
// hsv_mix
// Stage 5: finish the divide, place chroma and x per sector (zeros for grey), add m.
// ----------------------------------------------------------------------------
module hsv_mix
  import hsv_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    up_valid,
  output logic    up_ready,
  input  hsv_s4_t up_data,
  output logic    dn_valid,
  input  logic    dn_ready,
  output q15_t    red,
  output q15_t    green,
  output q15_t    blue
);

  logic [18:0] rem;
  q15_t        x;
  q15_t        c;
  q15_t        r_next;
  q15_t        g_next;
  q15_t        b_next;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    rem = up_data.quo - ({4'b0, up_data.est} << 4) + {4'b0, up_data.est};
    x   = {1'b0, up_data.est} + 16'(rem >= 19'(DIV_REST));
    c   = up_data.chroma;
    unique case (up_data.sector)
      SEC_R_TO_Y: begin r_next = c;     g_next = x;     b_next = '0;    end
      SEC_Y_TO_G: begin r_next = x;     g_next = c;     b_next = '0;    end
      SEC_G_TO_C: begin r_next = '0;    g_next = c;     b_next = x;     end
      SEC_C_TO_B: begin r_next = '0;    g_next = x;     b_next = c;     end
      SEC_B_TO_M: begin r_next = x;     g_next = '0;    b_next = c;     end
      default:    begin r_next = c;     g_next = '0;    b_next = x;     end
    endcase
    if (up_data.grey) begin
      r_next = '0;
      g_next = '0;
      b_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      red   <= r_next + up_data.m;
      green <= g_next + up_data.m;
      blue  <= b_next + up_data.m;
    end
  end

endmodule

FILE: test/tb_hsv_to_rgb_converter_unit.sv
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter_unit
// Self-checking bench for the HSV to RGB converter. A table of directed
// colors (pure hues, sector edges, grey, clamped inputs, out-of-range hue)
// is followed by about a thousand random colors. Every output item is
// checked in order against its table value or a color-math predictor. Both
// handshake sides idle at random, with a long output stall and a drain pause.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_converter_unit;
  import hsv_pkg::*;

  typedef struct packed {
    q15_t red;
    q15_t green;
    q15_t blue;
  } rgb_t;

  typedef struct packed {
    logic [12:0] hue;
    q15_t        sat;
    q15_t        bri;
    logic        typed;
    rgb_t        rgb;
  } color_row_t;

  localparam int NUM_RANDOM = 1000;
  localparam int NUM_DIRECTED = 20;

  logic clk;
  logic rst;

  hsv_in_if  pix_in();
  hsv_out_if pix_out();

  hsv_to_rgb_converter_unit uut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in.sink),
    .pix_out (pix_out.source)
  );

  rgb_t pending_rgb[$];
  int   mismatches = 0;
  int   tx_max_gap = 6;
  int   rx_max_gap = 6;
  int   hold_cycles = 0;

  color_row_t color_table [NUM_DIRECTED] = '{
    '{13'd0,    16'd32768, 16'd32768, 1'b1, '{16'd32768, 16'd0,     16'd0}},
    '{13'd960,  16'd32768, 16'd32768, 1'b1, '{16'd32768, 16'd32768, 16'd0}},
    '{13'd1920, 16'd32768, 16'd32768, 1'b1, '{16'd0,     16'd32768, 16'd0}},
    '{13'd2880, 16'd32768, 16'd32768, 1'b1, '{16'd0,     16'd32768, 16'd32768}},
    '{13'd3840, 16'd32768, 16'd32768, 1'b1, '{16'd0,     16'd0,     16'd32768}},
    '{13'd4800, 16'd32768, 16'd32768, 1'b1, '{16'd32768, 16'd0,     16'd32768}},
    '{13'd100,  16'd0,     16'd32768, 1'b1, '{16'd32768, 16'd32768, 16'd32768}},
    '{13'd2000, 16'd32768, 16'd0,     1'b1, '{16'd0,     16'd0,     16'd0}},
    '{13'd5760, 16'd32768, 16'd32768, 1'b1, '{16'd0,     16'd0,     16'd0}},
    '{13'd8191, 16'd0,     16'd32768, 1'b1, '{16'd32768, 16'd32768, 16'd32768}},
    '{13'd5760, 16'd16384, 16'd32768, 1'b1, '{16'd16384, 16'd16384, 16'd16384}},
    '{13'd0,    16'd65535, 16'd65535, 1'b1, '{16'd32768, 16'd0,     16'd0}},
    '{13'd959,  16'd32768, 16'd32768, 1'b0, '0},
    '{13'd5759, 16'd32768, 16'd32768, 1'b0, '0},
    '{13'd480,  16'd32767, 16'd32767, 1'b0, '0},
    '{13'd1919, 16'h5555,  16'hAAAA,  1'b0, '0},
    '{13'd3361, 16'hAAAA,  16'h5555,  1'b0, '0},
    '{13'd4321, 16'd1,     16'd32767, 1'b0, '0},
    '{13'd1234, 16'd20000, 16'd30000, 1'b0, '0},
    '{13'd7000, 16'd12345, 16'hFFFF,  1'b0, '0}
  };

  function automatic rgb_t predict_rgb(logic [12:0] hue, q15_t sat, q15_t bri);
    logic [31:0] s, v, c, m, f, x, r, g, b;
    logic [2:0]  sec;
    rgb_t        res;
    s = (sat > ONE) ? 32'(ONE) : 32'(sat);
    v = (bri > ONE) ? 32'(ONE) : 32'(bri);
    c = (v * s) >> 15;
    m = v - c;
    r = 0;
    g = 0;
    b = 0;
    if (hue < HUE_LIMIT) begin
      sec = 3'(hue / SPAN);
      f = 32'(hue % SPAN);
      if (sec[0] == 1'b0) begin
        x = (c * f) / 32'(SPAN);
      end else begin
        x = (c * (32'(SPAN) - f)) / 32'(SPAN);
      end
      case (sec)
        SEC_R_TO_Y: begin r = c; g = x; end
        SEC_Y_TO_G: begin r = x; g = c; end
        SEC_G_TO_C: begin g = c; b = x; end
        SEC_C_TO_B: begin g = x; b = c; end
        SEC_B_TO_M: begin r = x; b = c; end
        default:    begin r = c; b = x; end
      endcase
    end
    res.red   = 16'(r + m);
    res.green = 16'(g + m);
    res.blue  = 16'(b + m);
    return res;
  endfunction

  function automatic q15_t rand_level();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return ONE;
      2: return 16'd32767;
      3: return 16'($urandom_range(32769, 65535));
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic [12:0] rand_hue();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) begin
      return 13'($urandom_range(5760, 8191));
    end else if (k == 1) begin
      return 13'($urandom_range(0, 6) * 960 + $urandom_range(0, 2) - 1);
    end
    return 13'($urandom_range(0, 5759));
  endfunction

  // one color through the input channel; expectation queued at acceptance
  task automatic send_color(logic [12:0] hue, q15_t sat, q15_t bri, rgb_t want);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      pix_in.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_in.valid      = 1'b1;
    pix_in.hue        = hue;
    pix_in.saturation = sat;
    pix_in.brightness = bri;
    do @(posedge clk); while (!pix_in.ready);
    pending_rgb.push_back(want);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_rgb.size() != 0) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    rgb_t got, want;
    if (!rst && pix_out.valid && pix_out.ready) begin
      got = '{pix_out.red, pix_out.green, pix_out.blue};
      if (pending_rgb.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: r=%0d g=%0d b=%0d", got.red, got.green, got.blue);
      end else begin
        want = pending_rgb.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     want.red, want.green, want.blue, got.red, got.green, got.blue);
        end
      end
    end
  end

  // output side
  initial begin
    int gap;
    pix_out.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        gap = hold_cycles;
        hold_cycles = 0;
      end else begin
        gap = $urandom_range(0, rx_max_gap);
      end
      if (gap > 0) begin
        pix_out.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      pix_out.ready = 1'b1;
      do @(posedge clk); while (!pix_out.valid);
    end
  end

  // input side
  initial begin
    logic [12:0] hue;
    q15_t        sat, bri;
    rst = 1'b1;
    pix_in.valid = 1'b0;
    pix_in.hue = '0;
    pix_in.saturation = '0;
    pix_in.brightness = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    foreach (color_table[i]) begin
      send_color(color_table[i].hue, color_table[i].sat, color_table[i].bri,
                 color_table[i].typed ? color_table[i].rgb :
                 predict_rgb(color_table[i].hue, color_table[i].sat, color_table[i].bri));
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == 300) begin
        tx_max_gap = 0;
        rx_max_gap = 0;
      end else if (n == 500) begin
        // drain, then back up the pipe behind a long output stall
        pix_in.valid = 1'b0;
        wait_drained();
        rx_max_gap = 6;
        hold_cycles = 80;
      end else if (n == 540) begin
        tx_max_gap = 6;
      end
      hue = rand_hue();
      sat = rand_level();
      bri = rand_level();
      send_color(hue, sat, bri, predict_rgb(hue, sat, bri));
    end
    pix_in.valid = 1'b0;

    wait_drained();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && pending_rgb.size() == 0) begin
      $display("tb_hsv_to_rgb_converter_unit passed");
    end else begin
      $display("tb_hsv_to_rgb_converter_unit failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb_hsv_to_rgb_converter_unit failed");
    $finish;
  end

endmodule
